// File: rtl/unsigned_double_word_alu_top_defines.svh
// Assertion macros shared by the unsigned double-word ALU.
`ifndef UNSIGNED_DOUBLE_WORD_ALU_TOP_DEFINES_SVH
`define UNSIGNED_DOUBLE_WORD_ALU_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UDW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("udw assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define UDW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("udw assertion failed");

`endif

// File: rtl/udw_pkg.sv
// Shared types and constants of the unsigned double-word ALU.
package udw_pkg;

    localparam int HALF_W     = 32;
    localparam int WORD_W     = 2 * HALF_W;
    localparam int PORT_W     = 64;
    localparam int KIND_W     = 4;
    localparam int DIV_CNT_W  = $clog2(WORD_W);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Operation codes as they arrive on the request channel.
    typedef enum logic [KIND_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_MIN = 4'd5,
        OP_MAX = 4'd6,
        OP_EQ  = 4'd7,
        OP_INC = 4'd8,
        OP_DEC = 4'd9
    } t_op;

    // One classified operation waiting for the execution side.
    typedef struct packed {
        logic              op_ok;
        t_op               op;
        logic              b_zero;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_item;

    // Occupancy of the execution side, for checking.
    typedef struct packed {
        logic div_busy;
        logic s1_valid;
        logic s2_valid;
        logic out_valid;
    } t_back_status;

endpackage

// File: rtl/udw_req_if.sv
// Request and response channel interfaces of the unsigned double-word ALU.
interface udw_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [63:0] a_value;
    logic [63:0] b_value;

    modport source (output valid, output kind, output a_value, output b_value, input ready);
    modport sink   (input valid, input kind, input a_value, input b_value, output ready);
endinterface

interface udw_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic        divide_by_zero;

    modport source (output valid, output result_value, output divide_by_zero, input ready);
    modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

// File: rtl/udw_front.sv
// Front end: accepts requests, decodes the operation and registers the item.
module udw_front
    import udw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    udw_req_if.sink       i_req,
    output logic          o_valid,
    output t_item         o_item,
    input  logic          i_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  req_take;

    // A new transaction is taken when the stage is empty or drains this cycle.
    assign i_req.ready = !r_valid || !i_full;
    assign req_take    = i_req.valid && i_req.ready;

    // Decode the operation and mask the operands to the word width.
    always_comb begin
        n_item.op_ok  = (i_req.kind <= KIND_W'(OP_DEC));
        n_item.op     = n_item.op_ok ? t_op'(i_req.kind) : OP_ADD;
        n_item.a      = i_req.a_value[WORD_W-1:0];
        n_item.b      = i_req.b_value[WORD_W-1:0];
        n_item.b_zero = (n_item.b == '0);
    end

    // Holding register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (req_take) begin
            r_valid <= 1'b1;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
        if (req_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/udw_fifo.sv
// Short queue that decouples the front end from the execution side.
module udw_fifo
    import udw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  t_item                 i_wr_item,
    output logic                  o_full,
    output logic                  o_rd_valid,
    output t_item                 o_rd_item,
    input  logic                  i_rd_en,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  wr_en;
    logic                  rd_en;

    assign o_full     = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rptr];
    assign o_count    = r_count;
    assign wr_en      = i_wr_valid && !o_full;
    assign rd_en      = i_rd_en && o_rd_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

endmodule

// File: rtl/udw_back.sv
// Execution side: operate stage with iterative divider, product sum stage, output register.
module udw_back
    import udw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_item         i_item,
    output logic          o_take,
    udw_rsp_if.source     o_rsp,
    output t_back_status  o_status
);

    // Operate stage.
    logic                 r_s1_valid;
    t_item                r_s1_item;
    logic                 r_div_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_rem;
    logic [WORD_W-1:0]    r_quo;

    // Product sum stage.
    logic                 r_s2_valid;
    logic                 r_s2_mul;
    logic                 r_s2_dz;
    logic [WORD_W-1:0]    r_s2_res;
    logic [WORD_W-1:0]    r_pp0;
    logic [HALF_W-1:0]    r_pp1;
    logic [HALF_W-1:0]    r_pp2;

    // Output register.
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_res;
    logic                 r_out_dz;

    logic                 out_free;
    logic                 s2_adv;
    logic                 s2_free;
    logic                 s1_adv;
    logic                 s1_free;
    logic                 s1_load;
    logic                 load_div;

    logic [WORD_W:0]      div_shift;
    logic [WORD_W:0]      div_trial;
    logic [WORD_W-1:0]    n_rem;
    logic [WORD_W-1:0]    n_quo;

    logic [WORD_W-1:0]    sum;
    logic [WORD_W-1:0]    dif;
    logic                 a_lt_b;
    logic [WORD_W-1:0]    n_s2_res;
    logic                 n_s2_dz;
    logic [WORD_W-1:0]    n_pp0;
    logic [HALF_W-1:0]    n_pp1;
    logic [HALF_W-1:0]    n_pp2;
    logic [WORD_W-1:0]    n_out_res;

    // Stage advance chain, from the output back to the queue.
    assign out_free = !r_out_valid || o_rsp.ready;
    assign s2_adv   = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || s2_adv;
    assign s1_adv   = r_s1_valid && !r_div_busy && s2_free;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign s1_load  = i_valid && s1_free;
    assign o_take   = s1_load;
    assign load_div = i_item.op_ok && (i_item.op inside {OP_DIV, OP_MOD});

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    always_comb begin
        div_shift = {r_rem, r_quo[WORD_W-1]};
        div_trial = div_shift - {1'b0, r_s1_item.b};
        if (!div_trial[WORD_W]) begin
            n_rem = div_trial[WORD_W-1:0];
            n_quo = {r_quo[WORD_W-2:0], 1'b1};
        end else begin
            n_rem = div_shift[WORD_W-1:0];
            n_quo = {r_quo[WORD_W-2:0], 1'b0};
        end
    end

    // Operate stage registers and divider sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_div_busy <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
                r_div_busy <= load_div && !i_item.b_zero;
            end else begin
                if (s1_adv) begin
                    r_s1_valid <= 1'b0;
                end
                if (r_div_busy && (r_cnt == '0)) begin
                    r_div_busy <= 1'b0;
                end
            end
        end
        if (s1_load) begin
            r_s1_item <= i_item;
            r_cnt     <= DIV_CNT_W'(WORD_W - 1);
            if (i_item.b_zero) begin
                r_quo <= '0;
                r_rem <= i_item.a;
            end else begin
                r_quo <= i_item.a;
                r_rem <= '0;
            end
        end else if (r_div_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Simple operations and the partial products of the multiply.
    always_comb begin
        sum    = r_s1_item.a + ((r_s1_item.op == OP_INC) ? WORD_W'(1) : r_s1_item.b);
        dif    = r_s1_item.a - ((r_s1_item.op == OP_DEC) ? WORD_W'(1) : r_s1_item.b);
        a_lt_b = (r_s1_item.a < r_s1_item.b);
        case (r_s1_item.op)
            OP_ADD, OP_INC: n_s2_res = sum;
            OP_SUB, OP_DEC: n_s2_res = dif;
            OP_DIV:         n_s2_res = r_quo;
            OP_MOD:         n_s2_res = r_rem;
            OP_MIN:         n_s2_res = a_lt_b ? r_s1_item.a : r_s1_item.b;
            OP_MAX:         n_s2_res = a_lt_b ? r_s1_item.b : r_s1_item.a;
            OP_EQ:          n_s2_res = WORD_W'(r_s1_item.a == r_s1_item.b);
            default:        n_s2_res = '0;
        endcase
        if (!r_s1_item.op_ok) begin
            n_s2_res = '0;
        end
        n_s2_dz = r_s1_item.op_ok && r_s1_item.b_zero &&
                  (r_s1_item.op inside {OP_DIV, OP_MOD});
        n_pp0 = WORD_W'(r_s1_item.a[HALF_W-1:0]) * WORD_W'(r_s1_item.b[HALF_W-1:0]);
        n_pp1 = r_s1_item.a[HALF_W-1:0] * r_s1_item.b[WORD_W-1:HALF_W];
        n_pp2 = r_s1_item.a[WORD_W-1:HALF_W] * r_s1_item.b[HALF_W-1:0];
    end

    // Product sum stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_s2_mul <= r_s1_item.op_ok && (r_s1_item.op == OP_MUL);
            r_s2_dz  <= n_s2_dz;
            r_s2_res <= n_s2_res;
            r_pp0    <= n_pp0;
            r_pp1    <= n_pp1;
            r_pp2    <= n_pp2;
        end
    end

    // Cross products land in the upper half; anything above the word wraps away.
    assign n_out_res = r_s2_mul ? (r_pp0 + {r_pp1 + r_pp2, {HALF_W{1'b0}}}) : r_s2_res;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s2_adv) begin
            r_out_res <= n_out_res;
            r_out_dz  <= r_s2_dz;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_value   = PORT_W'(r_out_res);
    assign o_rsp.divide_by_zero = r_out_dz;

    assign o_status.div_busy  = r_div_busy;
    assign o_status.s1_valid  = r_s1_valid;
    assign o_status.s2_valid  = r_s2_valid;
    assign o_status.out_valid = r_out_valid;

endmodule

// File: rtl/unsigned_double_word_alu_top.sv
// Path: a request passes the front register, the queue, the operate stage, the product
// sum stage and the output register. Divide and modulo hold the operate stage while the
// divider runs, one quotient bit a cycle, unless the divisor is zero.
// Throughput: one transaction per cycle while the divider is idle and responses are taken.
// Reset: synchronous, active low; clears all valid flags and the divider, no payload reset.
`include "unsigned_double_word_alu_top_defines.svh"
module unsigned_double_word_alu_top
    import udw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    udw_req_if.sink    i_req,
    udw_rsp_if.source  o_rsp
);

    logic                  front_valid;
    t_item                 front_item;
    logic                  fifo_full;
    logic                  fifo_valid;
    t_item                 fifo_item;
    logic                  fifo_take;
    logic [FIFO_CNT_W-1:0] fifo_count;
    t_back_status          back_status;

    // Decode and register incoming transactions.
    udw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_full  (fifo_full)
    );

    // Queue between decode and execution.
    udw_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_item  (front_item),
        .o_full     (fifo_full),
        .o_rd_valid (fifo_valid),
        .o_rd_item  (fifo_item),
        .i_rd_en    (fifo_take),
        .o_count    (fifo_count)
    );

    // Execute and return responses.
    udw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fifo_valid),
        .i_item   (fifo_item),
        .o_take   (fifo_take),
        .o_rsp    (o_rsp),
        .o_status (back_status)
    );

    // The divider only runs with an item held in the operate stage.
    `UDW_ASSERT_NOW(a_div_has_item, back_status.div_busy, back_status.s1_valid)
    // The queue never reports more entries than it has.
    `UDW_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    // A decoded item blocked by a full queue is kept for the next cycle.
    `UDW_ASSERT_NEXT(a_front_holds, front_valid && fifo_full, front_valid)
    // A response that is not taken stays offered.
    `UDW_ASSERT_NEXT(a_out_holds, back_status.out_valid && !o_rsp.ready, back_status.out_valid)
    // The product sum stage keeps its item while the output is blocked.
    `UDW_ASSERT_NEXT(a_s2_holds,
        back_status.s2_valid && back_status.out_valid && !o_rsp.ready, back_status.s2_valid)

endmodule
